// File: design/swm_pkg.sv
package swm_pkg;

  // Fixed field widths
  localparam int SAMPLE_W = 32;
  localparam int RESULT_W = 33;
  localparam int WS_W     = 6;

  // Default window capacity
  localparam int WINDOW_MAX_DEF = 32;

  // Register port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register index codes (paddr bit 2 selects the register)
  localparam logic REG_WINDOW_SIZE = 1'b0;

  localparam logic [WS_W-1:0] WS_RESET = WS_W'(1);

  // Entry view that one cell shows its neighbors
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] val;
    logic                       valid;
    logic                       gt;
  } nb_t;

  // Broadcast control for the whole cell row
  typedef struct packed {
    logic                       upd;
    logic                       clear;
    logic                       full;
    logic                       flush;
    logic signed [SAMPLE_W-1:0] sample;
  } ctrl_t;

endpackage

// File: design/swm_stream_if.sv
interface swm_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [swm_pkg::SAMPLE_W-1:0] sample;
  logic                                 first;

  modport source (output valid, sample, first, input ready);
  modport sink   (input valid, sample, first, output ready);
endinterface

interface swm_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [swm_pkg::RESULT_W-1:0] median_x2;

  modport source (output valid, median_x2, input ready);
  modport sink   (input valid, median_x2, output ready);
endinterface

// File: design/swm_cell.sv
module swm_cell #(
  parameter int AGE_W = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  swm_pkg::ctrl_t       ctrl_i,
  input  logic [AGE_W-1:0]     k_m1_i,
  input  swm_pkg::nb_t         left_i,
  input  logic [AGE_W-1:0]     left_age_i,
  input  swm_pkg::nb_t         right_i,
  input  logic [AGE_W-1:0]     right_age_i,
  input  logic                 del_i,
  output logic                 del_o,
  output swm_pkg::nb_t         nb_o,
  output logic [AGE_W-1:0]     age_o
);

  logic signed [swm_pkg::SAMPLE_W-1:0] val_q, val_d;
  logic [AGE_W-1:0]                    age_q, age_d;
  logic                                valid_q, valid_d;
  logic                                eff_valid, del_here;
  swm_pkg::nb_t                        cur, prv;
  logic [AGE_W-1:0]                    cur_age, prv_age;

  // Own entry as seen by neighbors; a new sequence hides all old entries
  assign eff_valid = valid_q & ~ctrl_i.clear;
  assign nb_o.val   = val_q;
  assign nb_o.valid = eff_valid;
  assign nb_o.gt    = ~eff_valid | (val_q > ctrl_i.sample);
  assign age_o      = age_q;

  // Oldest entry leaves the window once it is full
  assign del_here = ctrl_i.full & eff_valid & (age_q == k_m1_i);
  assign del_o    = del_i | del_here;

  // Entries after the removed one close up by one place
  assign cur     = del_o ? right_i : nb_o;
  assign cur_age = del_o ? right_age_i : age_q;
  assign prv     = del_i ? nb_o : left_i;
  assign prv_age = del_i ? age_q : left_age_i;

  // Take left entry, the new sample, or keep the compacted entry
  always_comb begin
    if (prv.gt) begin
      val_d   = prv.val;
      valid_d = prv.valid;
      age_d   = prv_age + AGE_W'(1);
    end else if (cur.gt) begin
      val_d   = ctrl_i.sample;
      valid_d = 1'b1;
      age_d   = '0;
    end else begin
      val_d   = cur.val;
      valid_d = cur.valid;
      age_d   = cur_age + AGE_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.flush) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.upd) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.upd) begin
      val_q <= val_d;
      age_q <= age_d;
    end
  end

endmodule

// File: design/sliding_window_median_unit.sv
// Sliding-window median unit.
// sample_i takes one request per handshake: a signed 32-bit sample and a
// first flag that empties the window and starts a new sequence with it.
// result_o delivers twice the window median (33 bits signed, the sum of the
// two middle sorted values) for each sample that leaves the window full;
// samples that arrive while the window is still filling give no result.
// The window length is set by the window_size register over the APB port
// (byte address 0); writing it also empties the window. Write it only
// while the block is idle.
// Each accepted sample updates a row of WINDOW_MAX sorted cells: every
// cell compares its entry to the sample, the oldest entry drops out and
// the sample slides into place. The median of the updated row is then
// loaded into the output register, which drives result_o, once that
// register is empty or its result is being taken.
// Throughput is one sample per cycle while result_o is ready.
// When result_o stalls, one finished result waits in the cell row and a
// second in the output register; sample_i.ready then goes low.
// Reset empties the window and sets window_size to 1.
module sliding_window_median_unit #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  swm_sample_if.sink                     sample_i,
  swm_result_if.source                   result_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [swm_pkg::PADDR_W-1:0]    paddr,
  input  logic [swm_pkg::PDATA_W-1:0]    pwdata,
  output logic [swm_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);

  localparam int AGE_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW    = $clog2(WINDOW_MAX + 1);
  localparam int KW    = (CW > swm_pkg::WS_W) ? CW : swm_pkg::WS_W;

  logic [swm_pkg::WS_W-1:0]            ws_q;
  logic [CW-1:0]                       fill_q, fill_d, fill_base;
  logic                                pend_q, pend_d;
  logic                                out_valid_q;
  logic signed [swm_pkg::RESULT_W-1:0] out_q, sum;
  logic [KW-1:0]                       ws_ext, k_wide;
  logic [CW-1:0]                       k_eff, lo_idx, hi_idx;
  logic                                accept, load, cfg_we, full_now;
  swm_pkg::ctrl_t                      ctrl;
  swm_pkg::nb_t                        nb     [WINDOW_MAX];
  logic [AGE_W-1:0]                    age    [WINDOW_MAX];
  logic [WINDOW_MAX:0]                 dchain;
  logic [WINDOW_MAX-1:0]               valid_vec;
  logic signed [swm_pkg::SAMPLE_W-1:0] lo_val, hi_val;

  // Register port
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & (paddr[2] == swm_pkg::REG_WINDOW_SIZE);
  assign prdata = (paddr[2] == swm_pkg::REG_WINDOW_SIZE) ?
                  swm_pkg::PDATA_W'(ws_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q <= swm_pkg::WS_RESET;
    end else if (cfg_we) begin
      ws_q <= pwdata[swm_pkg::WS_W-1:0];
    end
  end

  // Effective window length: zero acts as one, clamp to capacity
  assign ws_ext = KW'(ws_q);
  always_comb begin
    if (ws_ext == '0) begin
      k_wide = KW'(1);
    end else if (ws_ext > KW'(WINDOW_MAX)) begin
      k_wide = KW'(WINDOW_MAX);
    end else begin
      k_wide = ws_ext;
    end
  end
  assign k_eff  = k_wide[CW-1:0];
  assign lo_idx = (k_eff - CW'(1)) >> 1;
  assign hi_idx = k_eff >> 1;

  // Request handshake and fill tracking
  assign load           = pend_q & (~out_valid_q | result_o.ready);
  assign sample_i.ready = ~pend_q | load;
  assign accept         = sample_i.valid & sample_i.ready;
  assign full_now       = ~sample_i.first & (fill_q == k_eff);

  always_comb begin
    fill_base = sample_i.first ? '0 : fill_q;
    fill_d    = (fill_base < k_eff) ? fill_base + CW'(1) : fill_base;
    pend_d    = accept ? (fill_d == k_eff) : (pend_q & ~load);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      pend_q <= 1'b0;
    end else if (cfg_we) begin
      fill_q <= '0;
      pend_q <= 1'b0;
    end else begin
      if (accept) begin
        fill_q <= fill_d;
      end
      pend_q <= pend_d;
    end
  end

  // Broadcast to the cell row
  assign ctrl.upd    = accept;
  assign ctrl.clear  = sample_i.first;
  assign ctrl.full   = full_now;
  assign ctrl.flush  = cfg_we;
  assign ctrl.sample = sample_i.sample;

  assign dchain[0] = 1'b0;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    swm_pkg::nb_t     left_nb, right_nb;
    logic [AGE_W-1:0] left_age, right_age;

    if (i == 0) begin : g_first
      assign left_nb  = '{val: '0, valid: 1'b0, gt: 1'b0};
      assign left_age = '0;
    end else begin : g_mid_l
      assign left_nb  = nb[i-1];
      assign left_age = age[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_last
      assign right_nb  = '{val: '0, valid: 1'b0, gt: 1'b1};
      assign right_age = '0;
    end else begin : g_mid_r
      assign right_nb  = nb[i+1];
      assign right_age = age[i+1];
    end

    swm_cell #(
      .AGE_W (AGE_W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .k_m1_i      (AGE_W'(k_eff - CW'(1))),
      .left_i      (left_nb),
      .left_age_i  (left_age),
      .right_i     (right_nb),
      .right_age_i (right_age),
      .del_i       (dchain[i]),
      .del_o       (dchain[i+1]),
      .nb_o        (nb[i]),
      .age_o       (age[i])
    );

    assign valid_vec[i] = nb[i].valid;
  end

  // Pick the two middle entries of the sorted row
  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      lo_val = lo_val | (nb[i].val & {swm_pkg::SAMPLE_W{lo_idx == CW'(i)}});
      hi_val = hi_val | (nb[i].val & {swm_pkg::SAMPLE_W{hi_idx == CW'(i)}});
    end
  end
  assign sum = swm_pkg::RESULT_W'(lo_val) + swm_pkg::RESULT_W'(hi_val);

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= sum;
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.median_x2 = out_q;

  // Checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= k_eff) else $error("fill count beyond window length");

  a_fill_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sample_i.first |-> $countones(valid_vec) == int'(fill_q))
    else $error("valid cells disagree with fill count");

  a_one_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && full_now |-> dchain[WINDOW_MAX])
    else $error("full window without an entry to drop");

  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && full_now |=> pend_q) else $error("full window gave no result");

  a_no_drop_filling: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full_now |-> !dchain[WINDOW_MAX]) else $error("entry dropped while filling");

endmodule

// File: test/sliding_window_median_checker.sv
module sliding_window_median_checker #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  swm_sample_if                         sample_mon,
  swm_result_if                         result_mon,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [swm_pkg::PADDR_W-1:0]   paddr,
  input  logic [swm_pkg::PDATA_W-1:0]   pwdata,
  output int unsigned                   mismatch_count_o,
  output int unsigned                   medians_due_o
);
  import swm_pkg::*;

  // Window copy: arrival order and ascending order
  logic signed [SAMPLE_W-1:0] arrival_q [WINDOW_MAX];
  logic signed [SAMPLE_W-1:0] sorted_q  [WINDOW_MAX];
  int unsigned                fill_n;
  int unsigned                slot;
  logic [WS_W-1:0]            win_reg;

  logic signed [RESULT_W-1:0] expected_medians [$];
  int unsigned                mismatches;

  task automatic flag_mismatch(string msg);
    $display("median mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Clamp the register into 1..WINDOW_MAX
  function automatic int unsigned window_len();
    int unsigned k;
    k = win_reg;
    if (k == 0) k = 1;
    if (k > WINDOW_MAX) k = WINDOW_MAX;
    return k;
  endfunction

  // Slide v into sorted_q[0..n-1] from the top
  task automatic sort_in(int unsigned n, logic signed [SAMPLE_W-1:0] v);
    int unsigned i;
    i = n;
    while (i > 0 && sorted_q[i-1] > v) begin
      sorted_q[i] = sorted_q[i-1];
      i--;
    end
    sorted_q[i] = v;
  endtask

  // Drop the first entry equal to v, closing the gap
  task automatic sort_out(int unsigned n, logic signed [SAMPLE_W-1:0] v);
    int unsigned i;
    i = 0;
    while (i < n && sorted_q[i] != v) i++;
    for (; i + 1 < n; i++) sorted_q[i] = sorted_q[i+1];
  endtask

  // Advance the window by one sample and queue its doubled median when full
  task automatic take_sample(logic signed [SAMPLE_W-1:0] s, logic first_flag);
    int unsigned                k;
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
    k = window_len();
    if (first_flag) begin
      fill_n = 0;
      slot   = 0;
    end
    if (slot >= k) slot = 0;
    if (fill_n < k) begin
      sort_in(fill_n, s);
      fill_n++;
    end else begin
      sort_out(k, arrival_q[slot]);
      sort_in(k - 1, s);
    end
    arrival_q[slot] = s;
    slot++;
    if (slot >= k) slot = 0;
    if (fill_n == k) begin
      // odd window: both indexes name the middle entry
      lo = sorted_q[(k - 1) / 2];
      hi = sorted_q[k / 2];
      expected_medians.push_back({lo[SAMPLE_W-1], lo} + {hi[SAMPLE_W-1], hi});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [RESULT_W-1:0] want;
    if (!rst_ni) begin
      foreach (arrival_q[i]) arrival_q[i] = '0;
      foreach (sorted_q[i]) sorted_q[i] = '0;
      fill_n  = 0;
      slot    = 0;
      win_reg = WS_RESET;
      expected_medians.delete();
      mismatches = 0;
      medians_due_o    <= 0;
      mismatch_count_o <= 0;
    end else begin
      // compare a delivered median with the oldest one due
      if (result_mon.valid && result_mon.ready) begin
        if (expected_medians.size() == 0) begin
          flag_mismatch($sformatf("median_x2 %0d with none due", result_mon.median_x2));
        end else begin
          want = expected_medians.pop_front();
          if (result_mon.median_x2 !== want)
            flag_mismatch($sformatf("median_x2 %0d, want %0d", result_mon.median_x2, want));
        end
      end
      // register write: new length, empty window; other indexes are ignored
      if (psel && penable && pwrite && pready && paddr[2] == REG_WINDOW_SIZE) begin
        win_reg = pwdata[WS_W-1:0];
        fill_n  = 0;
        slot    = 0;
      end
      if (sample_mon.valid && sample_mon.ready)
        take_sample(sample_mon.sample, sample_mon.first);
      medians_due_o    <= expected_medians.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

// File: test/sliding_window_median_unit_test.sv
module sliding_window_median_unit_test;
  import swm_pkg::*;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int RANDOM_SAMPLES = 1150;

  localparam logic [PADDR_W-1:0] WINDOW_SIZE_ADDR = {REG_WINDOW_SIZE, 2'b00};
  localparam logic [PADDR_W-1:0] UNMAPPED_ADDR    = {~REG_WINDOW_SIZE, 2'b00};

  localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7fff_ffff;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int unsigned mismatch_count;
  int unsigned medians_due;
  int unsigned cycle_count = 0;
  bit          calm = 1'b0;

  swm_sample_if sample_bus();
  swm_result_if result_bus();

  sliding_window_median_unit dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_bus),
    .result_o (result_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  sliding_window_median_checker median_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .sample_mon       (sample_bus),
    .result_mon       (result_bus),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .mismatch_count_o (mismatch_count),
    .medians_due_o    (medians_due)
  );

  always #5 clk_i = ~clk_i;

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sliding_window_median_unit regression: fail");
      $finish;
    end
  end

  // Stall the result side at random, never while calm
  always @(negedge clk_i) begin
    result_bus.ready <= calm || ($urandom_range(99) >= 36);
  end

  // Offer one request after a random gap; return at the negedge after it is taken
  task automatic send_sample(logic signed [SAMPLE_W-1:0] value, logic first_flag);
    while (!calm && $urandom_range(99) < 36) begin
      sample_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    sample_bus.valid  <= 1'b1;
    sample_bus.sample <= value;
    sample_bus.first  <= first_flag;
    do @(posedge clk_i); while (!sample_bus.ready);
    @(negedge clk_i);
  endtask

  // Hold requests until every due median has come, then let the pipe settle
  task automatic wait_idle();
    sample_bus.valid <= 1'b0;
    while (medians_due != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_window(logic [PDATA_W-1:0] len);
    wait_idle();
    write_reg(WINDOW_SIZE_ADDR, len);
  endtask

  // Mix extremes, a narrow band that makes ties, and full-range values
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return S_MIN;
      1:       return S_MAX;
      2, 3, 4: return int'($urandom_range(8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  // Extremes and out-of-range lengths every few phases, short windows otherwise
  function automatic logic [PDATA_W-1:0] pick_window(int unsigned phase);
    case (phase % 8)
      0:       return 32;
      1:       return $urandom_range(33, 63);
      2:       return 0;
      3:       return 1;
      4:       return 63;
      default: return $urandom_range(2, 9);
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned span;
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    sample_bus.valid  = 1'b0;
    sample_bus.sample = '0;
    sample_bus.first  = 1'b0;
    result_bus.ready  = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset window of one: each sample is its own median
    send_sample(S_MIN, 1'b1);
    send_sample(S_MAX, 1'b0);
    send_sample('0, 1'b0);
    send_sample(-1, 1'b0);

    // zero length acts as one
    set_window(0);
    send_sample(3, 1'b0);
    send_sample(-3, 1'b0);

    // even window at the extremes of the sum
    set_window(2);
    send_sample(S_MIN, 1'b0);
    send_sample(S_MIN, 1'b0);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MAX, 1'b0);

    // ties, then a restart in mid-window
    set_window(3);
    repeat (4) send_sample(7, 1'b0);
    send_sample(9, 1'b1);
    send_sample(9, 1'b0);
    send_sample(1, 1'b0);

    // random phases, each with its own window length
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_SAMPLES) begin
      set_window(pick_window(phase));
      calm = (phase == 3);
      span = $urandom_range(40, 110) + 32;
      for (int unsigned n = 0; n < span && sent < RANDOM_SAMPLES; n++) begin
        // let the block drain completely now and then
        if ((phase == 1 && n == 20) || $urandom_range(199) == 0) wait_idle();
        // a write to an unmapped index must leave the window alone
        if (phase == 5 && n == 30) begin
          wait_idle();
          write_reg(UNMAPPED_ADDR, 5);
        end
        send_sample(pick_sample(), $urandom_range(31) == 0);
        sent++;
      end
      phase++;
    end
    calm = 1'b0;

    wait_idle();
    if (mismatch_count == 0 && medians_due == 0) begin
      $display("sliding_window_median_unit regression: pass");
    end else begin
      $display("sliding_window_median_unit regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
design/swm_pkg.sv
design/swm_stream_if.sv
design/swm_cell.sv
design/sliding_window_median_unit.sv
test/sliding_window_median_checker.sv
test/sliding_window_median_unit_test.sv
